### hw/rtl/packed_trit_store_top_assert.svh
// Assertion macros used by the checker of the packed trit store.
`ifndef PACKED_TRIT_STORE_TOP_ASSERT_SVH
`define PACKED_TRIT_STORE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/pts_pkg.sv
`default_nettype none
package pts_pkg;

    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 56;
    localparam int INDEX_W     = 16;
    localparam int TRIT_W      = 2;
    localparam int LANE_W      = 4;
    localparam int WORD_IDX_W  = INDEX_W - LANE_W;
    localparam int CNT_W       = 13;
    localparam int CAP_W       = 13;
    localparam int INIT_W      = 9;
    localparam int PACK_W      = 32;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = 1;
    localparam int Q_CNT_W     = 2;

    localparam logic [INIT_W-1:0] INIT_WORDS_RST = 9'd7;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    localparam logic [TRIT_W-1:0] TRIT_UNKNOWN = 2'd0;
    localparam logic [TRIT_W-1:0] TRIT_FALSE   = 2'd1;
    localparam logic [TRIT_W-1:0] TRIT_TRUE    = 2'd2;
    localparam logic [TRIT_W-1:0] TRIT_ALIAS   = 2'd3;

    typedef struct packed {
        logic                  kind;
        logic [WORD_IDX_W-1:0] word;
        logic [LANE_W-1:0]     lane;
        logic [TRIT_W-1:0]     value;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_q2b;

    typedef struct packed {
        logic              range_error;
        logic [INIT_W-1:0] capacity_words;
        logic [CNT_W-1:0]  unknown_count;
        logic [CNT_W-1:0]  false_count;
        logic [CNT_W-1:0]  true_count;
        logic [TRIT_W-1:0] read_trit;
    } t_result;

    function automatic logic [TRIT_W-1:0] norm_trit(input logic [TRIT_W-1:0] code);
        return (code == TRIT_ALIAS) ? TRIT_TRUE : code;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/packed_trit_store_top.sv
// Path to the master side: input queue, stage-two register, output register.
// Throughput: one word per cycle unless stalled by the master side or a clearing pass;
// read-modify-write uses one memory read and one write port and forwards the last write.
// Reset is synchronous and active low; it and every configuration write start a clearing
// pass over all WORD_DEPTH words of the trit memory, while the slave side is not ready.
`default_nettype none
module packed_trit_store_top #(
    parameter int WORD_DEPTH = 256
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [pts_pkg::INIT_W-1:0]     i_cfg_wr_data,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // trit_index [15:0], trit_value [17:16], zero fill [23:18]
    input  wire logic [pts_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // kind [0]
    input  wire logic                           i_s_tuser,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // read_trit [1:0], true_count [14:2], false_count [27:15], unknown_count [40:28],
    // capacity_words [49:41], range_error [50], zero fill [55:51]
    output logic [pts_pkg::OUT_DATA_W-1:0]      o_m_tdata
);
    import pts_pkg::*;

    t_q2b q;
    logic pop;
    logic clearing;

    pts_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_hold     (clearing),
        .i_pop      (pop),
        .o_q        (q)
    );

    pts_back #(
        .WORD_DEPTH (WORD_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q           (q),
        .o_pop         (pop),
        .o_clearing    (clearing),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata)
    );

endmodule
`default_nettype wire

### hw/rtl/pts_front.sv
`default_nettype none
module pts_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_tvalid,
    output logic                              o_s_tready,
    input  wire logic [pts_pkg::IN_DATA_W-1:0] i_s_tdata,
    input  wire logic                         i_s_tuser,
    input  wire logic                         i_hold,
    input  wire logic                         i_pop,
    output pts_pkg::t_q2b                     o_q
);
    import pts_pkg::*;

    t_op                r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_cnt, n_cnt;
    logic               push;
    logic               pop;
    t_op                in_op;
    logic [TRIT_W-1:0]  in_val;

    assign in_val          = i_s_tdata[INDEX_W +: TRIT_W];
    assign in_op.kind      = i_s_tuser;
    assign in_op.word      = i_s_tdata[LANE_W +: WORD_IDX_W];
    assign in_op.lane      = i_s_tdata[LANE_W-1:0];
    assign in_op.value     = norm_trit(in_val);

    assign o_s_tready = (r_cnt < Q_CNT_W'(Q_DEPTH)) && !i_hold;
    assign push       = i_s_tvalid && o_s_tready;
    assign pop        = i_pop && (r_cnt != '0);

    assign o_q.valid = (r_cnt != '0);
    assign o_q.op    = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_cnt    = r_cnt + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_op;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/pts_back.sv
`default_nettype none
module pts_back #(
    parameter int WORD_DEPTH = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [pts_pkg::INIT_W-1:0]    i_cfg_wr_data,
    input  pts_pkg::t_q2b                      i_q,
    output logic                               o_pop,
    output logic                               o_clearing,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic [pts_pkg::OUT_DATA_W-1:0]     o_m_tdata
);
    import pts_pkg::*;

    localparam int AW = (WORD_DEPTH > 1) ? $clog2(WORD_DEPTH) : 1;
    localparam logic [INDEX_W:0] DEPTH_V = (INDEX_W + 1)'(WORD_DEPTH);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(WORD_DEPTH - 1);

    logic [PACK_W-1:0] r_mem [WORD_DEPTH];
    logic [PACK_W-1:0] r_rdata;

    logic              r_clearing;
    logic [AW-1:0]     r_clr_cnt;
    logic [CAP_W-1:0]  r_cap, n_cap;
    logic [CNT_W-1:0]  r_true, n_true;
    logic [CNT_W-1:0]  r_false, n_false;
    logic              r_s2_valid;
    t_op               r_s2_op;
    logic              r_fwd_valid;
    logic [WORD_IDX_W-1:0] r_fwd_word;
    logic [PACK_W-1:0] r_fwd_data;
    logic              r_out_valid;
    t_result           r_out, n_out;

    logic [CAP_W-1:0]  cfg_cap;
    logic              s2_fire;
    logic [PACK_W-1:0] cur_word, new_word;
    logic [TRIT_W-1:0] old_trit;
    logic              below_cap;
    logic              in_range;
    logic              do_write;
    logic              grow;
    logic              err;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [PACK_W-1:0] mem_wdata;
    logic [LANE_W:0]   bit_pos;

    assign cfg_cap = ((INDEX_W + 1)'(i_cfg_wr_data) > DEPTH_V) ? DEPTH_V[CAP_W-1:0]
                                                                : CAP_W'(i_cfg_wr_data);

    assign s2_fire    = r_s2_valid && (!r_out_valid || i_m_tready);
    assign o_pop      = i_q.valid && !r_clearing && (!r_s2_valid || s2_fire);
    assign o_clearing = r_clearing;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_W'(r_out);

    always_comb begin
        cur_word  = (r_fwd_valid && (r_fwd_word == r_s2_op.word)) ? r_fwd_data : r_rdata;
        bit_pos   = {r_s2_op.lane, 1'b0};
        old_trit  = norm_trit(cur_word[bit_pos +: TRIT_W]);
        below_cap = {1'b0, r_s2_op.word} < r_cap;
        in_range  = (INDEX_W + 1)'(r_s2_op.word) < DEPTH_V;
        grow      = (r_s2_op.kind == KIND_WRITE) && !below_cap
                    && (r_s2_op.value != TRIT_UNKNOWN) && in_range;
        err       = (r_s2_op.kind == KIND_WRITE) && !below_cap
                    && (r_s2_op.value != TRIT_UNKNOWN) && !in_range;
        do_write  = (r_s2_op.kind == KIND_WRITE) && (below_cap || grow);

        new_word = cur_word;
        new_word[bit_pos +: TRIT_W] = r_s2_op.value;

        n_cap   = r_cap;
        n_true  = r_true;
        n_false = r_false;
        if (do_write) begin
            if (grow) begin
                n_cap = CAP_W'(r_s2_op.word) + 1'b1;
            end
            n_true  = r_true - CNT_W'(old_trit == TRIT_TRUE)
                      + CNT_W'(r_s2_op.value == TRIT_TRUE);
            n_false = r_false - CNT_W'(old_trit == TRIT_FALSE)
                      + CNT_W'(r_s2_op.value == TRIT_FALSE);
        end

        n_out.read_trit      = (r_s2_op.kind == KIND_READ && below_cap) ? old_trit
                                                                        : TRIT_UNKNOWN;
        n_out.true_count     = n_true;
        n_out.false_count    = n_false;
        n_out.unknown_count  = {n_cap[INIT_W-1:0], {LANE_W{1'b0}}} - n_true - n_false;
        n_out.capacity_words = n_cap[INIT_W-1:0];
        n_out.range_error    = err;

        mem_we    = r_clearing || (s2_fire && do_write);
        mem_waddr = r_clearing ? r_clr_cnt : AW'(r_s2_op.word);
        mem_wdata = r_clearing ? '0 : new_word;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (o_pop) begin
            r_rdata <= r_mem[AW'(i_q.op.word)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s2_op <= i_q.op;
        end
        if (s2_fire) begin
            r_out <= n_out;
        end
        if (s2_fire && do_write) begin
            r_fwd_word <= r_s2_op.word;
            r_fwd_data <= new_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_cnt   <= '0;
            r_cap       <= CAP_W'(INIT_WORDS_RST) > DEPTH_V[CAP_W-1:0] && DEPTH_V < 17'd4096
                           ? DEPTH_V[CAP_W-1:0] : CAP_W'(INIT_WORDS_RST);
            r_true      <= '0;
            r_false     <= '0;
            r_s2_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_clearing  <= 1'b1;
            r_clr_cnt   <= '0;
            r_cap       <= cfg_cap;
            r_true      <= '0;
            r_false     <= '0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == LAST_ADDR) begin
                    r_clearing <= 1'b0;
                end
            end
            if (o_pop) begin
                r_s2_valid <= 1'b1;
            end else if (s2_fire) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_fire) begin
                r_cap       <= n_cap;
                r_true      <= n_true;
                r_false     <= n_false;
                r_out_valid <= 1'b1;
                if (do_write) begin
                    r_fwd_valid <= 1'b1;
                end
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

### hw/rtl/pts_checker.sv
`default_nettype none
`include "packed_trit_store_top_assert.svh"
module pts_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_cfg_wr_en,
    input wire logic                           o_s_tready,
    input wire logic                           o_m_tvalid,
    input wire logic                           i_m_tready,
    input wire logic [pts_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import pts_pkg::*;

    t_result          res;
    logic [CNT_W-1:0] sum;
    logic [CNT_W-1:0] total;

    assign res   = t_result'(o_m_tdata[$bits(t_result)-1:0]);
    assign sum   = res.true_count + res.false_count + res.unknown_count;
    assign total = {res.capacity_words, {LANE_W{1'b0}}};

    `PTS_ASSERT_NOW(a_counts_cover_capacity, o_m_tvalid, sum == total, "counts do not add up to capacity")
    `PTS_ASSERT_NOW(a_read_code_legal, o_m_tvalid, res.read_trit != TRIT_ALIAS, "read trit code three")
    `PTS_ASSERT_NOW(a_error_only_on_write, o_m_tvalid && res.range_error, res.read_trit == TRIT_UNKNOWN, "range error with read data")
    `PTS_ASSERT_NEXT(a_cfg_starts_clear, i_cfg_wr_en, !o_s_tready, "ready during clearing pass")
    `PTS_ASSERT_NEXT(a_result_held, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "stalled result changed")

endmodule

bind packed_trit_store_top pts_checker u_pts_checker (.*);
`default_nettype wire
